FILE: hw/rtl/open_addressing_hash_table_assert.svh
// Assertion macros used by the checker file of the hash table.
`ifndef OPEN_ADDRESSING_HASH_TABLE_ASSERT_SVH
`define OPEN_ADDRESSING_HASH_TABLE_ASSERT_SVH
// Implication checked on every rising edge outside reset.
`define OAHT_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// Implication whose consequent is checked in the cycle after its antecedent.
`define OAHT_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`endif

FILE: hw/rtl/oaht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash table package
// Shared types, opcodes and defaults for the open-addressing hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;
    localparam int unsigned DefCapacity = 256;
    localparam logic [7:0] DefLoadLimit = 8'd192;

    localparam logic [1:0] OP_GET = 2'd0;
    localparam logic [1:0] OP_SET = 2'd1;
    localparam logic [1:0] OP_DEL = 2'd2;

    localparam logic [1:0] KIND_EMPTY = 2'd0;
    localparam logic [1:0] KIND_FULL  = 2'd1;
    localparam logic [1:0] KIND_TOMB  = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] key_id;
        logic [31:0] key_hash;
        logic [63:0] value_in;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [63:0] value_out;
        logic        status;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } t_state;
endpackage

FILE: hw/rtl/oaht_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash table channel interfaces
// Valid/ready channels for requests, responses and the configuration write.
// ----------------------------------------------------------------------------
interface oaht_req_if;
    import oaht_pkg::*;
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface oaht_rsp_if;
    import oaht_pkg::*;
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface oaht_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/open_addressing_hash_table.sv
`timescale 1ns / 1ps
// Each request probes from 1 to CAPACITY slots, a slot read and a check per slot.
// One request at a time: a new request is taken only after the response is
// accepted; a table write overlaps the response cycle.
// After reset a clearing pass marks every slot empty; no request is accepted
// during it. Load limit resets to 192.
// ----------------------------------------------------------------------------
// Open-addressing hash table
// Linear probing map with tombstones held in one slot RAM.
// ----------------------------------------------------------------------------
module open_addressing_hash_table #(
    parameter int unsigned CAPACITY = oaht_pkg::DefCapacity
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    oaht_req_if.sink   req,
    oaht_rsp_if.source rsp,
    oaht_cfg_if.sink   cfg
);
    import oaht_pkg::*;

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = (AW + 1 > 8) ? AW + 1 : 8;

    t_state        r_state, n_state;
    t_req          r_req;
    logic [AW-1:0] r_idx;
    logic [AW:0]   r_cnt;
    logic          r_have_tomb;
    logic [AW-1:0] r_tomb;
    logic [AW:0]   r_used;
    logic [7:0]    r_limit;
    t_rsp          r_rsp;
    logic          r_we, n_we;
    logic [AW-1:0] r_waddr, n_waddr;
    logic [97:0]   r_wdata, n_wdata;
    logic [97:0]   w_rdata;
    logic [1:0]    w_kind;
    logic          w_op_ok;
    logic          w_match;
    logic          w_last;
    logic          w_end;
    logic          w_room;
    logic          w_ins_tomb;
    logic          w_ins_empty;

    assign w_kind = w_rdata[97:96];
    assign w_op_ok = (r_req.opcode == OP_GET) || (r_req.opcode == OP_SET) ||
                     (r_req.opcode == OP_DEL);
    assign w_match = (w_kind == KIND_FULL) && (w_rdata[95:64] == r_req.key_id);
    assign w_last = (r_cnt == (AW + 1)'(CAPACITY - 1));
    assign w_end = (w_kind == KIND_EMPTY) || w_last;
    assign w_room = CW'(r_used) < CW'(r_limit);
    // A set takes the first tombstone on its path before any empty slot.
    assign w_ins_tomb = r_have_tomb || (w_kind == KIND_TOMB);
    assign w_ins_empty = !w_ins_tomb && (w_kind == KIND_EMPTY) && w_room;

    assign req.ready = (r_state == ST_IDLE);
    assign rsp.valid = (r_state == ST_DONE);
    assign rsp.payload = r_rsp;
    assign cfg.ready = 1'b1;

    oaht_slot_mem #(.AW(AW)) u_mem (
        .i_clk  (i_clk),
        .i_raddr(r_idx),
        .o_rdata(w_rdata),
        .i_we   (r_we),
        .i_waddr(r_waddr),
        .i_wdata(r_wdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_idx == AW'(CAPACITY - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (req.valid) n_state = ST_READ;
            ST_READ:  n_state = ST_CHECK;
            ST_CHECK: n_state = (!w_op_ok || w_match || w_end) ? ST_DONE : ST_READ;
            ST_DONE:  if (rsp.ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_we    = 1'b0;
        n_waddr = r_idx;
        n_wdata = {KIND_FULL, r_req.key_id, r_req.value_in};
        unique case (r_state)
            ST_CLEAR: begin
                n_we    = 1'b1;
                n_wdata = {KIND_EMPTY, 96'd0};
            end
            ST_CHECK: begin
                if (w_op_ok && w_match) begin
                    n_we = (r_req.opcode != OP_GET);
                    if (r_req.opcode == OP_DEL) begin
                        n_wdata = {KIND_TOMB, 96'd0};
                    end
                end else if (w_op_ok && w_end && r_req.opcode == OP_SET) begin
                    n_we    = w_ins_tomb || w_ins_empty;
                    n_waddr = r_have_tomb ? r_tomb : r_idx;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_idx   <= '0;
            r_used  <= '0;
            r_limit <= DefLoadLimit;
            r_we    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_we    <= n_we;
            r_waddr <= n_waddr;
            r_wdata <= n_wdata;
            if (cfg.valid) begin
                r_limit <= cfg.data;
            end
            unique case (r_state)
                ST_CLEAR: r_idx <= r_idx + 1'b1;
                ST_IDLE: begin
                    if (req.valid) begin
                        r_req       <= req.payload;
                        r_idx       <= req.payload.key_hash[AW-1:0];
                        r_cnt       <= '0;
                        r_have_tomb <= 1'b0;
                        r_rsp       <= '0;
                    end
                end
                ST_CHECK: begin
                    if (w_op_ok && w_match) begin
                        if (r_req.opcode != OP_SET) begin
                            r_rsp.hit <= 1'b1;
                        end
                        if (r_req.opcode == OP_GET) begin
                            r_rsp.value_out <= w_rdata[63:0];
                        end
                    end else if (w_op_ok && w_end) begin
                        if (r_req.opcode == OP_SET) begin
                            if (w_ins_tomb) begin
                                r_rsp.hit <= 1'b1;
                            end else if (w_ins_empty) begin
                                r_rsp.hit <= 1'b1;
                                r_used    <= r_used + 1'b1;
                            end else begin
                                r_rsp.status <= 1'b1;
                            end
                        end
                    end else if (w_op_ok) begin
                        if (w_kind == KIND_TOMB && !r_have_tomb) begin
                            r_have_tomb <= 1'b1;
                            r_tomb      <= r_idx;
                        end
                        r_idx <= r_idx + 1'b1;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end
endmodule

FILE: hw/rtl/oaht_slot_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash table slot memory
// One synchronous RAM of slot kind, key and value with registered read data.
// ----------------------------------------------------------------------------
module oaht_slot_mem #(
    parameter int unsigned AW = 8
) (
    input  logic          i_clk,
    input  logic [AW-1:0] i_raddr,
    output logic [97:0]   o_rdata,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [97:0]   i_wdata
);
    logic [97:0] r_mem [(1 << AW)];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: hw/rtl/oaht_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash table port checker
// Watches the top-level channels for response ordering and payload rules.
// ----------------------------------------------------------------------------
`include "open_addressing_hash_table_assert.svh"
module oaht_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_valid,
    input logic        i_req_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic        i_rsp_hit,
    input logic        i_rsp_status,
    input logic [63:0] i_rsp_value
);
    `OAHT_ASSERT_IMP(a_no_req_while_rsp, i_clk, i_rst_n, i_rsp_valid, !i_req_ready, "request accepted while response pending")
    `OAHT_ASSERT_IMP(a_full_no_hit, i_clk, i_rst_n, i_rsp_valid && i_rsp_status, !i_rsp_hit && i_rsp_value == 64'd0, "refused set reports hit or value")
    `OAHT_ASSERT_NEXT(a_no_rsp_after_req, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_rsp_valid, "response appeared one cycle after request")
    `OAHT_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_value), "stalled response changed")
endmodule

bind open_addressing_hash_table oaht_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (req.valid),
    .i_req_ready (req.ready),
    .i_rsp_valid (rsp.valid),
    .i_rsp_ready (rsp.ready),
    .i_rsp_hit   (rsp.payload.hit),
    .i_rsp_status(rsp.payload.status),
    .i_rsp_value (rsp.payload.value_out)
);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash table testbench
// Drives get, set, delete and unknown-opcode requests into the hash table, predicts every
// response with a behavioral model of the probe, and compares field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import oaht_pkg::*;

    localparam int Cap = 256;
    localparam int CycleLimit = 3000000;
    localparam logic [1:0] OP_RSVD = 2'd3;

    logic i_clk;
    logic i_rst_n;

    oaht_req_if req ();
    oaht_rsp_if rsp ();
    oaht_cfg_if cfg ();

    open_addressing_hash_table #(.CAPACITY(Cap)) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .req(req.sink),
        .rsp(rsp.source),
        .cfg(cfg.sink)
    );

    // Model of the table.
    logic [1:0]  mdl_kind [Cap];
    logic [31:0] mdl_key [Cap];
    logic [63:0] mdl_value [Cap];
    int unsigned mdl_used;
    logic [7:0]  mdl_limit;

    t_rsp expected_rsp [$];
    int   fail_count;
    int   send_idle_pct;
    int   stall_pct;
    int   hold_off;
    longint cycle_count;

    // Keys in use draw from a small pool so that hits and collisions are common.
    logic [31:0] key_pool [64];
    logic [31:0] hash_pool [64];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CycleLimit) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic t_rsp predict_access(t_req r);
        t_rsp res;
        int idx;
        int tomb;
        int match;
        int free_slot;
        bit free_empty;
        bit have_free;
        res = '0;
        if (r.opcode != OP_GET && r.opcode != OP_SET && r.opcode != OP_DEL) begin
            return res;
        end
        idx = r.key_hash % Cap;
        tomb = -1;
        match = -1;
        have_free = 0;
        free_slot = 0;
        free_empty = 0;
        for (int n = 0; n < Cap; n++) begin
            if (mdl_kind[idx] == KIND_EMPTY) begin
                have_free = 1;
                free_slot = (tomb >= 0) ? tomb : idx;
                free_empty = (tomb < 0);
                break;
            end
            if (mdl_kind[idx] == KIND_FULL) begin
                if (mdl_key[idx] == r.key_id) begin
                    match = idx;
                    break;
                end
            end else if (tomb < 0) begin
                tomb = idx;
            end
            idx = (idx + 1) % Cap;
        end
        if (match < 0 && !have_free && tomb >= 0) begin
            have_free = 1;
            free_slot = tomb;
            free_empty = 0;
        end
        case (r.opcode)
            OP_GET: begin
                if (match >= 0) begin
                    res.hit = 1'b1;
                    res.value_out = mdl_value[match];
                end
            end
            OP_SET: begin
                if (match >= 0) begin
                    mdl_value[match] = r.value_in;
                end else if (!have_free || (free_empty && mdl_used + 1 > mdl_limit)) begin
                    res.status = 1'b1;
                end else begin
                    if (free_empty) mdl_used++;
                    mdl_kind[free_slot] = KIND_FULL;
                    mdl_key[free_slot] = r.key_id;
                    mdl_value[free_slot] = r.value_in;
                    res.hit = 1'b1;
                end
            end
            default: begin
                if (match >= 0) begin
                    mdl_kind[match] = KIND_TOMB;
                    res.hit = 1'b1;
                end
            end
        endcase
        return res;
    endfunction

    // Valid stays high after an accepted request until the next one or a pause.
    task automatic send_request(t_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            req.valid <= 1'b0;
            @(negedge i_clk);
        end
        req.valid <= 1'b1;
        req.payload <= r;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        expected_rsp.push_back(predict_access(r));
        @(negedge i_clk);
    endtask

    task automatic drain_responses();
        req.valid <= 1'b0;
        while (expected_rsp.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_limit(logic [7:0] lim);
        drain_responses();
        cfg.valid <= 1'b1;
        cfg.data <= lim;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        mdl_limit = lim;
        @(negedge i_clk);
        cfg.valid <= 1'b0;
    endtask

    function automatic t_req make_op(logic [1:0] op, int k, logic [63:0] v);
        t_req r;
        r.opcode = op;
        r.key_id = key_pool[k];
        r.key_hash = hash_pool[k];
        r.value_in = v;
        return r;
    endfunction

    function automatic logic [63:0] rand_value();
        return {$urandom(), $urandom()};
    endfunction

    // Response checker: sampled at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp.valid && rsp.ready) begin
            if (expected_rsp.size() == 0) begin
                $error("response with no request outstanding");
                fail_count++;
            end else begin
                t_rsp e;
                e = expected_rsp.pop_front();
                if (rsp.payload.hit !== e.hit) begin
                    $error("hit expected %0h actual %0h", e.hit, rsp.payload.hit);
                    fail_count++;
                end
                if (rsp.payload.value_out !== e.value_out) begin
                    $error("value_out expected %0h actual %0h", e.value_out,
                           rsp.payload.value_out);
                    fail_count++;
                end
                if (rsp.payload.status !== e.status) begin
                    $error("status expected %0h actual %0h", e.status, rsp.payload.status);
                    fail_count++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off--;
            rsp.ready <= 1'b0;
        end else begin
            rsp.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic test_directed();
        // Extremes of key and hash, and values with every bit both ways.
        send_request(make_op(OP_GET, 0, '0));
        send_request(make_op(OP_DEL, 0, '0));
        send_request(make_op(OP_SET, 0, 64'hFFFF_FFFF_FFFF_FFFF));
        send_request(make_op(OP_SET, 0, 64'h0));
        send_request(make_op(OP_GET, 0, '0));
        send_request(make_op(OP_SET, 1, 64'hA5A5_5A5A_0F0F_F0F0));
        send_request(make_op(OP_SET, 2, 64'h5A5A_A5A5_F0F0_0F0F));
        send_request(make_op(OP_GET, 1, '1));
        send_request(make_op(OP_DEL, 1, '0));
        send_request(make_op(OP_GET, 1, '0));
        // The freed slot becomes a tombstone that a set may reuse.
        send_request(make_op(OP_SET, 3, 64'h1234));
        send_request(make_op(OP_GET, 2, '0));
        send_request(make_op(OP_DEL, 2, '0));
        send_request(make_op(OP_DEL, 2, '0));
        // Unknown opcode leaves the table alone.
        send_request(make_op(OP_RSVD, 3, '1));
        send_request(make_op(OP_GET, 3, '0));
        // A limit of one refuses sets that need an empty slot.
        write_limit(8'd1);
        send_request(make_op(OP_SET, 4, 64'h77));
        send_request(make_op(OP_SET, 3, 64'h88));
        send_request(make_op(OP_GET, 3, '0));
        send_request(make_op(OP_DEL, 3, '0));
        send_request(make_op(OP_SET, 5, 64'h99));
        write_limit(8'd192);
    endtask

    task automatic random_burst(int n, int wide_pool);
        for (int i = 0; i < n; i++) begin
            int k;
            int p;
            logic [1:0] op;
            k = $urandom_range(wide_pool - 1);
            p = $urandom_range(99);
            op = (p < 45) ? OP_SET : (p < 75) ? OP_GET : (p < 97) ? OP_DEL : OP_RSVD;
            send_request(make_op(op, k, rand_value()));
        end
    endtask

    task automatic test_random_phases();
        send_idle_pct = 0;  stall_pct = 0;  random_burst(250, 64);
        send_idle_pct = 56; stall_pct = 0;  random_burst(200, 64);
        write_limit(8'd255);
        send_idle_pct = 0;  stall_pct = 56; random_burst(200, 64);
        write_limit(8'd20);
        send_idle_pct = 13; stall_pct = 13; random_burst(200, 64);
        write_limit(8'd192);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off = 300;
        random_burst(40, 64);
        // The sender pauses until every response is in.
        drain_responses();
        random_burst(40, 64);
    endtask

    // A high limit lets keys and tombstones pile up along the probe paths.
    task automatic test_full_table();
        write_limit(8'd255);
        send_idle_pct = 0;
        stall_pct = 0;
        random_burst(150, 64);
    endtask

    initial begin
        fail_count = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off = 0;
        mdl_used = 0;
        mdl_limit = 8'd192;
        for (int i = 0; i < Cap; i++) begin
            mdl_kind[i] = KIND_EMPTY;
            mdl_key[i] = '0;
            mdl_value[i] = '0;
        end
        // Key 0 and the top key and hash, then many keys clustered on few hashes.
        key_pool[0] = 32'hFFFF_FFFF;
        hash_pool[0] = 32'hFFFF_FFFF;
        for (int i = 1; i < 64; i++) begin
            key_pool[i] = (i == 1) ? 32'd0 : $urandom();
            hash_pool[i] = (i == 1) ? 32'd0 :
                           {24'($urandom_range(32'hFFFFFF)), 8'($urandom_range(7))};
        end
        key_pool[2] = 32'h0000_0001;
        hash_pool[2] = 32'hFFFF_FF00;
        req.valid = 1'b0;
        req.payload = '0;
        rsp.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random_phases();
        test_backpressure();
        test_full_table();
        send_idle_pct = 0;
        stall_pct = 0;
        drain_responses();
        repeat (600) @(negedge i_clk);
        if (fail_count == 0 && expected_rsp.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
